FILE: hdl/r255_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package r255_pkg;

   // Digits per group; the last one closes the group
   localparam int unsigned GROUP_LEN = 5;
   localparam logic [2:0] LAST_DIGIT = 3'(GROUP_LEN - 1);
   localparam logic [7:0] TAIL_KEY_RESET = 8'hBE;

   // One queued transaction: up to four bytes, most significant byte first
   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  count;
      logic        tail;
   } r255_entry_type;

   // Weight of digit position idx, modulo 2^32
   function automatic logic [31:0] pow255(input logic [2:0] idx);
      logic [31:0] w;
      unique case (idx)
         3'd0:    w = 32'h0000_0001;
         3'd1:    w = 32'h0000_00FF;
         3'd2:    w = 32'h0000_FE01;
         3'd3:    w = 32'h00FD_02FF;
         3'd4:    w = 32'hFC05_FC01;
         default: w = 32'h0000_0000;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/radix255_group_decoder_unit.sv
// Radix-255 group decoder.
// Input queue port (req_): push a byte with req_push while req_full is low;
// req_end marks the last byte of a stream. Every fifth byte of a stream
// closes a group d0..d4 (least significant first); the group value
// sum d[i]*255^i, wrapped to 32 bits, comes out as four result bytes, most
// significant first, with rsp_tail low. A stream end that leaves one to
// four bytes of an open group returns those bytes in arrival order, XORed
// with the tail key, rsp_tail high. rsp_last flags the final result of the
// input transaction.
// Result queue port (rsp_): the oldest result is shown while rsp_empty is
// low and is taken with rsp_pop. The first result is registered in the
// queue, then in the output register. Throughput: one input byte per
// cycle while req_full is low; a front stage holding one 8x32 multiply-add
// feeds a QUEUE_DEPTH-entry queue, and the output stage drains one byte
// per cycle while rsp_pop is high. When the receiver stalls the queue
// fills and req_full rises. csr_we writes the tail key (reset 0xBE).
// Reset: synchronous; clears the open group, the queue and the output.
`timescale 1ns / 1ps
`default_nettype none

module radix255_group_decoder_unit
   import r255_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output      logic       req_full,
   input  wire logic [7:0] req_byte,
   input  wire logic       req_end,
   input  wire logic       rsp_pop,
   output      logic       rsp_empty,
   output      logic [7:0] rsp_byte,
   output      logic       rsp_tail,
   output      logic       rsp_last,
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata
);

   logic           accept;
   logic           push;
   r255_entry_type push_entry;
   logic           q_pop;
   logic           q_nonempty;
   r255_entry_type q_head;

   assign accept = req_push && !req_full;

   // Classify bytes and form group values
   r255_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_byte   (req_byte),
      .req_end    (req_end),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decouple front and back
   r255_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .full       (req_full),
      .nonempty   (q_nonempty),
      .head       (q_head)
   );

   // Serialize entries into result bytes
   r255_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_nonempty (q_nonempty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_byte   (rsp_byte),
      .rsp_tail   (rsp_tail),
      .rsp_last   (rsp_last)
   );

endmodule

`default_nettype wire

FILE: hdl/r255_front.sv
`timescale 1ns / 1ps
`default_nettype none

module r255_front
   import r255_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic [7:0]     req_byte,
   input  wire logic           req_end,
   input  wire logic           csr_we,
   input  wire logic [7:0]     csr_wdata,
   output      logic           push,
   output      r255_entry_type push_entry
);

   logic [7:0]  key_ff;
   logic [2:0]  count_ff, count_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  digit_ff [4];
   logic [39:0] product;
   logic [31:0] sum;
   logic        closing;
   logic [7:0]  tail_byte [4];

   // Weighted digit added to the running group value
   assign product = {32'd0, req_byte} * {8'd0, pow255(count_ff)};
   assign sum     = ((count_ff == 3'd0) ? 32'd0 : acc_ff) + product[31:0];
   assign closing = (count_ff == LAST_DIGIT);

   // Assemble leftover bytes in arrival order, keyed
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         tail_byte[k] = ((3'(k) == count_ff) ? req_byte : digit_ff[k]) ^ key_ff;
      end
   end

   // Classify the transaction and build the queue entry
   always_comb begin
      count_in = count_ff;
      acc_in   = acc_ff;
      push     = 1'b0;
      push_entry.data  = {tail_byte[0], tail_byte[1], tail_byte[2], tail_byte[3]};
      push_entry.count = count_ff + 3'd1;
      push_entry.tail  = 1'b1;
      if (accept) begin
         if (closing) begin
            push             = 1'b1;
            push_entry.data  = sum;
            push_entry.count = 3'd4;
            push_entry.tail  = 1'b0;
            count_in         = 3'd0;
         end else begin
            acc_in = sum;
            if (req_end) begin
               push     = 1'b1;
               count_in = 3'd0;
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
      end
   end

   // Hold control state and key
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         key_ff   <= TAIL_KEY_RESET;
      end else begin
         count_ff <= count_in;
         if (csr_we) begin
            key_ff <= csr_wdata;
         end
      end
   end

   // Store the digit and running value
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (accept && !closing) begin
         digit_ff[count_ff[1:0]] <= req_byte;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/r255_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module r255_fifo
   import r255_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire r255_entry_type push_entry,
   input  wire logic           pop,
   output      logic           full,
   output      logic           nonempty,
   output      r255_entry_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   r255_entry_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign nonempty = (cnt_ff != '0);
   assign head     = mem_ff[rd_ptr_ff];
   assign do_pop   = pop && nonempty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Write the entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/r255_back.sv
`timescale 1ns / 1ps
`default_nettype none

module r255_back
   import r255_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           q_nonempty,
   input  wire r255_entry_type q_head,
   output      logic           q_pop,
   input  wire logic           rsp_pop,
   output      logic           rsp_empty,
   output      logic [7:0]     rsp_byte,
   output      logic           rsp_tail,
   output      logic           rsp_last
);

   logic        valid_ff, valid_in;
   logic [31:0] data_ff, data_in;
   logic [2:0]  rem_ff, rem_in;
   logic        tail_ff, tail_in;
   logic        taken, final_byte;

   assign rsp_empty  = !valid_ff;
   assign rsp_byte   = data_ff[31:24];
   assign rsp_tail   = tail_ff;
   assign final_byte = (rem_ff == 3'd1);
   assign rsp_last   = final_byte;
   assign taken      = valid_ff && rsp_pop;
   assign q_pop      = q_nonempty && (!valid_ff || (taken && final_byte));

   // Shift out the next byte or load the next entry
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      rem_in   = rem_ff;
      tail_in  = tail_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         data_in  = q_head.data;
         rem_in   = q_head.count;
         tail_in  = q_head.tail;
      end else if (taken) begin
         if (final_byte) begin
            valid_in = 1'b0;
         end else begin
            data_in = {data_ff[23:0], 8'd0};
            rem_in  = rem_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold output payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rem_ff  <= rem_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire

FILE: hdl/r255_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module r255_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_full,
   input wire logic       rsp_pop,
   input wire logic       rsp_empty,
   input wire logic [7:0] rsp_byte,
   input wire logic       rsp_tail,
   input wire logic       rsp_last
);

   // Output drains and input opens right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_open: assert property (@(posedge clock) $past(reset) |-> !req_full)
      else $error("input queue full after reset");

   // Stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_byte) && $stable(rsp_tail) && $stable(rsp_last)))
      else $error("stalled result changed");

   // Results of one transaction follow without a gap and share their kind
   a_burst: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last) |=>
         (!rsp_empty && rsp_tail == $past(rsp_tail)))
      else $error("transaction results broken up or mixed");

endmodule

bind radix255_group_decoder_unit r255_checker u_checker (.*);

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import r255_pkg::GROUP_LEN;
   import r255_pkg::TAIL_KEY_RESET;

   // Wait after the last result before touching the tail key
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      logic [7:0] value;
      logic       tail;
      logic       last;
   } out_byte_type;

   // Tracks the open group and tail key; holds the bytes still owed by the block
   class radix_decode_tracker;
      logic [7:0]   key;
      logic [7:0]   digits[4];
      int           held;
      out_byte_type owed[$];
      int           errors;

      function new();
         key    = TAIL_KEY_RESET;
         held   = 0;
         errors = 0;
      endfunction

      function void set_key(logic [7:0] k);
         key = k;
      endfunction

      function int owed_count();
         return owed.size();
      endfunction

      // Fold one accepted digit into the group and queue what it releases
      function void absorb_digit(logic [7:0] b, logic closes);
         logic [63:0]  acc;
         logic [31:0]  word;
         out_byte_type item;
         int           i;
         if (held == GROUP_LEN - 1) begin
            acc = {56'd0, b};
            for (i = 3; i >= 0; i--)
               acc = acc * 64'd255 + {56'd0, digits[i]};
            word = acc[31:0];
            for (i = 0; i < 4; i++) begin
               item.value = word[8 * (3 - i) +: 8];
               item.tail  = 1'b0;
               item.last  = (i == 3);
               owed.push_back(item);
            end
            held = 0;
         end else begin
            digits[held] = b;
            held++;
            if (closes) begin
               for (i = 0; i < held; i++) begin
                  item.value = digits[i] ^ key;
                  item.tail  = 1'b1;
                  item.last  = (i == held - 1);
                  owed.push_back(item);
               end
               held = 0;
            end
         end
      endfunction

      // Compare one popped result with the oldest owed byte
      function void match_output(logic [7:0] value, logic tail, logic last);
         out_byte_type want;
         if (owed.size() == 0) begin
            $error("unexpected result: byte %02h tail %0b last %0b", value, tail, last);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (value !== want.value) begin
            $error("rsp_byte: expected %02h, got %02h", want.value, value);
            errors++;
         end
         if (tail !== want.tail) begin
            $error("rsp_tail: expected %0b, got %0b", want.tail, tail);
            errors++;
         end
         if (last !== want.last) begin
            $error("rsp_last: expected %0b, got %0b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_byte = 8'd0;
   logic       req_end = 1'b0;
   logic       rsp_pop = 1'b0;
   logic       rsp_empty;
   logic [7:0] rsp_byte;
   logic       rsp_tail;
   logic       rsp_last;
   logic       csr_we = 1'b0;
   logic [7:0] csr_wdata = 8'd0;

   bit send_busy = 1'b0;
   bit drain_busy = 1'b0;

   radix_decode_tracker tracker = new();

   radix255_group_decoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_byte  (req_byte),
      .req_end   (req_end),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_byte  (rsp_byte),
      .rsp_tail  (rsp_tail),
      .rsp_last  (rsp_last),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #4_000_000;
      $display("radix255_group_decoder_unit regression: fail");
      $finish;
   end

   // Push one byte, hold it until the block takes it
   task automatic send_byte(input logic [7:0] b, input logic closes);
      int gap;
      gap = send_busy ? $urandom_range(16, 0) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_byte <= b;
      req_end  <= closes;
      do @(posedge clock); while (req_full);
      tracker.absorb_digit(b, closes);
   endtask

   task automatic send_stream(input logic [7:0] bytes[$], input bit closes);
      foreach (bytes[i])
         send_byte(bytes[i], closes && (i == bytes.size() - 1));
   endtask

   // Hold off the input until every owed result has been popped
   task automatic wait_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (tracker.owed_count() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key(input logic [7:0] k);
      csr_wdata <= k;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      tracker.set_key(k);
   endtask

   // Random streams: mostly closed by an end byte, some left open to run on
   task automatic run_streams(input int n_items);
      int         sent;
      int         len;
      int         i;
      bit         closes;
      logic [7:0] b;
      sent = 0;
      while (sent < n_items) begin
         send_busy  = ($urandom_range(3, 0) != 0);
         drain_busy = ($urandom_range(3, 0) != 0);
         len    = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 13)
                                              : $urandom_range(12, 1);
         closes = ($urandom_range(9, 0) != 0);
         for (i = 0; i < len; i++) begin
            case ($urandom_range(7, 0))
               0:       b = 8'h00;
               1:       b = 8'hFF;
               default: b = 8'($urandom_range(255, 0));
            endcase
            send_byte(b, closes && (i == len - 1));
         end
         sent += len;
      end
   endtask

   // Result side: random stall per result byte, check on every pop
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = drain_busy ? $urandom_range(16, 0) : 0;
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         tracker.match_output(rsp_byte, rsp_tail, rsp_last);
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero group, all-255 group that wraps, end on a full group,
      // then tails of one to four bytes under the reset key
      drain_busy = 1'b1;
      send_busy  = 1'b1;
      send_stream('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0);
      send_stream('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
      send_busy = 1'b0;
      send_stream('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05}, 1'b1);
      send_stream('{8'h00}, 1'b1);
      send_stream('{8'hFF, 8'h5A}, 1'b1);
      send_stream('{8'h01, 8'h80, 8'h7F}, 1'b1);
      send_stream('{8'hAA, 8'h55, 8'hFF, 8'h00}, 1'b1);
      wait_drained();

      write_key(8'h00);
      run_streams(100);
      wait_drained();

      // Pause the sender mid-phase until the queue fully drains
      write_key(8'hFF);
      run_streams(50);
      wait_drained();
      run_streams(50);
      wait_drained();

      write_key(8'($urandom_range(255, 0)));
      run_streams(150);
      wait_drained();

      write_key(8'($urandom_range(255, 0)));
      run_streams(150);
      wait_drained();

      if (tracker.errors == 0)
         $display("radix255_group_decoder_unit regression: pass");
      else
         $display("radix255_group_decoder_unit regression: fail");
      $finish;
   end

endmodule
